@@ sv/mbm_pkg.sv @@
// shared constants, types and tables for the mono bitmap magnifier
package mbm_pkg;

    localparam int BITMAP_SIZE_DEF  = 256;
    localparam int MAX_MAG_LOG2_DEF = 4;

    localparam int MAG_W      = 3;
    localparam int GRID_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int SRC_W     = 8;
    localparam int COL_W     = 5;
    localparam int ROW_W     = 8;
    localparam int COORD_W   = 12;
    localparam int PIX_W     = 64;
    localparam int CELL_W    = 16;
    localparam int LANES     = 8;
    localparam int ROW_PIX_W = 2 * PIX_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SHOWN = 2'd2;

    localparam logic [MAG_W-1:0]  MAG_RESET      = 3'd1;
    localparam logic [GRID_W-1:0] GRID_MIN_RESET = 4'd2;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             gaps;
    } lane_ctl_t;

    // gap pattern per factor, bit 0 leftmost, clears the rightmost pixel of each cell
    function automatic logic [CELL_W-1:0] gap_mask(input logic [MAG_W-1:0] mag);
        logic [CELL_W-1:0] m;
        case (mag)
            3'd2:    m = 16'h7777;
            3'd3:    m = 16'h7F7F;
            3'd4:    m = 16'h7FFF;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    // one cell of replicated pixels, as wide as the factor
    function automatic logic [CELL_W-1:0] cell_ones(input logic [MAG_W-1:0] mag);
        logic [CELL_W-1:0] m;
        case (mag)
            3'd2:    m = 16'h000F;
            3'd3:    m = 16'h00FF;
            3'd4:    m = 16'hFFFF;
            default: m = 16'h0003;
        endcase
        return m;
    endfunction

endpackage

@@ sv/mbm_if.sv @@
// valid/ready channel interfaces for input bytes and magnified rows
interface mbm_in_if;
    logic                       valid;
    logic                       ready;
    logic [mbm_pkg::SRC_W-1:0]  src_byte;
    logic [mbm_pkg::COL_W-1:0]  byte_col;
    logic [mbm_pkg::ROW_W-1:0]  src_row;

    modport source (output valid, output src_byte, output byte_col, output src_row,
                    input ready);
    modport sink   (input valid, input src_byte, input byte_col, input src_row,
                    output ready);
endinterface

interface mbm_out_if;
    logic                         valid;
    logic                         ready;
    logic [mbm_pkg::COORD_W-1:0]  dest_row;
    logic [mbm_pkg::COORD_W-1:0]  dest_x;
    logic [mbm_pkg::PIX_W-1:0]    pixels_lo;
    logic [mbm_pkg::PIX_W-1:0]    pixels_hi;
    logic                         last;

    modport source (output valid, output dest_row, output dest_x, output pixels_lo,
                    output pixels_hi, output last, input ready);
    modport sink   (input valid, input dest_row, input dest_x, input pixels_lo,
                    input pixels_hi, input last, output ready);
endinterface

@@ sv/mbm_lane.sv @@
// one pixel lane: replicates a source pixel into a cell and applies the gap pattern
module mbm_lane (
    input  logic                         pixel,
    input  mbm_pkg::lane_ctl_t           ctl,
    output logic [mbm_pkg::CELL_W-1:0]   lane_pix
);

    logic [mbm_pkg::CELL_W-1:0] mask;

    assign mask     = ctl.gaps ? mbm_pkg::gap_mask(ctl.mag) : {mbm_pkg::CELL_W{1'b1}};
    assign lane_pix = pixel ? (mbm_pkg::cell_ones(ctl.mag) & mask) : '0;

endmodule

@@ sv/mbm_merge.sv @@
// packs the lane cells side by side into one magnified row
module mbm_merge (
    input  logic [mbm_pkg::LANES-1:0][mbm_pkg::CELL_W-1:0] cells,
    input  mbm_pkg::lane_ctl_t                             ctl,
    output logic [mbm_pkg::ROW_PIX_W-1:0]                  row_pix
);

    always_comb
    begin
        row_pix = '0;
        case (ctl.mag)
            3'd2:
            begin
                for (int i = 0; i < mbm_pkg::LANES; i++)
                begin
                    row_pix[i*4 +: 4] = cells[i][3:0];
                end
            end
            3'd3:
            begin
                for (int i = 0; i < mbm_pkg::LANES; i++)
                begin
                    row_pix[i*8 +: 8] = cells[i][7:0];
                end
            end
            3'd4:
            begin
                for (int i = 0; i < mbm_pkg::LANES; i++)
                begin
                    row_pix[i*16 +: 16] = cells[i];
                end
            end
            default:
            begin
                for (int i = 0; i < mbm_pkg::LANES; i++)
                begin
                    row_pix[i*2 +: 2] = cells[i][1:0];
                end
            end
        endcase
    end

endmodule

@@ sv/mono_bitmap_magnifier.sv @@
// mono bitmap magnifier top level: config registers, lanes, row sequencer, output register
//
// Each accepted byte is expanded by eight pixel lanes and a merge stage into one magnified
// row, held in a row stage while a sub-row counter sends out 2^mag_log2 results (2, 4, 8
// or 16) through an output register, one per cycle unless out_ch.ready holds them back.
// The next byte is taken in the cycle its predecessor's last row moves to the output
// register, so items follow back to back. A byte's first result passes through the row
// stage and then the output register. mag_log2 of 0 acts as 1, values above MAX_MAG_LOG2
// saturate; src_row wraps at the bitmap size, which must be a power of two, and byte_col
// at an eighth of it. Configuration may be written only while no item is in flight.
module mono_bitmap_magnifier #(
    parameter int BITMAP_SIZE  = mbm_pkg::BITMAP_SIZE_DEF,
    parameter int MAX_MAG_LOG2 = mbm_pkg::MAX_MAG_LOG2_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbm_pkg::CFG_DATA_W-1:0]      cfg_data,
    mbm_in_if.sink                              in_ch,
    mbm_out_if.source                           out_ch
);

    localparam int RW = $clog2(BITMAP_SIZE);
    localparam int CW = $clog2(BITMAP_SIZE / 8);
    localparam int KW = MAX_MAG_LOG2;

    // configuration registers
    logic [mbm_pkg::MAG_W-1:0]  mag_reg;
    logic [mbm_pkg::GRID_W-1:0] grid_min_reg;
    logic                       grid_shown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg        <= mbm_pkg::MAG_RESET;
            grid_min_reg   <= mbm_pkg::GRID_MIN_RESET;
            grid_shown_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbm_pkg::CFG_MAG_LOG2:   mag_reg        <= cfg_data[mbm_pkg::MAG_W-1:0];
                mbm_pkg::CFG_GRID_MIN:   grid_min_reg   <= cfg_data[mbm_pkg::GRID_W-1:0];
                mbm_pkg::CFG_GRID_SHOWN: grid_shown_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective factor and gap decision
    logic [mbm_pkg::MAG_W-1:0] eff_mag;
    logic                      gaps;
    mbm_pkg::lane_ctl_t        lane_ctl;

    always_comb
    begin
        if (mag_reg == '0)
            eff_mag = mbm_pkg::MAG_W'(1);
        else if (mag_reg > mbm_pkg::MAG_W'(MAX_MAG_LOG2))
            eff_mag = mbm_pkg::MAG_W'(MAX_MAG_LOG2);
        else
            eff_mag = mag_reg;
    end

    assign gaps = (eff_mag >= mbm_pkg::MAG_W'(2)) &&
                  ((mbm_pkg::GRID_W'(eff_mag) < grid_min_reg) || !grid_shown_reg);
    assign lane_ctl = '{mag: eff_mag, gaps: gaps};

    // pixel lanes and merge
    logic [mbm_pkg::LANES-1:0][mbm_pkg::CELL_W-1:0] cells;
    logic [mbm_pkg::ROW_PIX_W-1:0]                  row_pix;

    for (genvar g = 0; g < mbm_pkg::LANES; g++)
    begin : g_lane
        mbm_lane u_lane (
            .pixel    (in_ch.src_byte[g]),
            .ctl      (lane_ctl),
            .lane_pix (cells[g])
        );
    end

    mbm_merge u_merge (
        .cells   (cells),
        .ctl     (lane_ctl),
        .row_pix (row_pix)
    );

    // coordinates of the incoming byte
    logic [RW-1:0]                row_idx;
    logic [CW-1:0]                col_idx;
    logic [mbm_pkg::COORD_W-1:0]  row_base_next;
    logic [mbm_pkg::COORD_W-1:0]  x_next;
    logic [KW-1:0]                last_k_next;

    assign row_idx       = in_ch.src_row[RW-1:0];
    assign col_idx       = in_ch.byte_col[CW-1:0];
    assign row_base_next = mbm_pkg::COORD_W'(row_idx) << eff_mag;
    assign x_next        = mbm_pkg::COORD_W'(col_idx) << (eff_mag + mbm_pkg::MAG_W'(3));
    assign last_k_next   = ~({KW{1'b1}} << eff_mag);

    // row stage with sub-row counter
    logic                         a_valid_reg;
    logic [mbm_pkg::ROW_PIX_W-1:0] a_pix_reg;
    logic [mbm_pkg::COORD_W-1:0]  a_row_reg;
    logic [mbm_pkg::COORD_W-1:0]  a_x_reg;
    logic [KW-1:0]                a_cnt_reg;
    logic [KW-1:0]                a_last_k_reg;
    logic                         a_gaps_reg;

    // output register
    logic                         out_valid_reg;
    logic [mbm_pkg::COORD_W-1:0]  out_row_reg;
    logic [mbm_pkg::COORD_W-1:0]  out_x_reg;
    logic [mbm_pkg::PIX_W-1:0]    out_lo_reg;
    logic [mbm_pkg::PIX_W-1:0]    out_hi_reg;
    logic                         out_last_reg;

    logic out_load;
    logic emit;
    logic a_last;
    logic a_done;
    logic in_acc;
    logic blank;

    assign out_load = !out_valid_reg || out_ch.ready;
    assign emit     = a_valid_reg && out_load;
    assign a_last   = (a_cnt_reg == a_last_k_reg);
    assign a_done   = emit && a_last;
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign blank    = a_gaps_reg && a_last;

    assign in_ch.ready = !a_valid_reg || a_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_cnt_reg   <= '0;
        end
        else if (in_acc)
        begin
            a_valid_reg <= 1'b1;
            a_cnt_reg   <= '0;
        end
        else if (a_done)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            a_cnt_reg <= a_cnt_reg + KW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg    <= row_pix;
            a_row_reg    <= row_base_next;
            a_x_reg      <= x_next;
            a_last_k_reg <= last_k_next;
            a_gaps_reg   <= gaps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg  <= a_row_reg | mbm_pkg::COORD_W'(a_cnt_reg);
            out_x_reg    <= a_x_reg;
            out_lo_reg   <= blank ? '0 : a_pix_reg[mbm_pkg::PIX_W-1:0];
            out_hi_reg   <= blank ? '0 : a_pix_reg[mbm_pkg::ROW_PIX_W-1:mbm_pkg::PIX_W];
            out_last_reg <= a_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.dest_row  = out_row_reg;
    assign out_ch.dest_x    = out_x_reg;
    assign out_ch.pixels_lo = out_lo_reg;
    assign out_ch.pixels_hi = out_hi_reg;
    assign out_ch.last      = out_last_reg;

`ifndef SYNTH
    // counter steps by one per row sent while the byte is not finished
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !a_done && !in_acc |=> a_cnt_reg == $past(a_cnt_reg) + KW'(1))
        else $error("sub-row counter did not advance");

    // a finished byte with no successor leaves the row stage empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        a_done && !in_acc |=> !a_valid_reg)
        else $error("row stage still busy after last row");

    // the final row of a gapped cell is blank and marked last
    a_blank_row: assert property (@(posedge clk) disable iff (!rst_n)
        emit && a_gaps_reg && a_last |=>
            out_ch.last && out_ch.pixels_lo == '0 && out_ch.pixels_hi == '0)
        else $error("gap row not cleared");

    // a new byte enters a busy row stage only when its last row moves to the output register this cycle
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && a_valid_reg |-> out_load && a_last)
        else $error("byte accepted over unfinished item");
`endif

endmodule

@@ verif/mbm_row_checker.sv @@
// row checker for the mono bitmap magnifier: predicts magnified rows and compares them
module mbm_row_checker
    import mbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mbm_in_if                     in_mon,
    mbm_out_if                    out_mon,
    output int                    fails,
    output int                    pending
);

    typedef struct packed {
        logic [COORD_W-1:0] dest_row;
        logic [COORD_W-1:0] dest_x;
        logic [PIX_W-1:0]   pixels_lo;
        logic [PIX_W-1:0]   pixels_hi;
        logic               last;
    } mag_row_t;

    // shadow copy of the block's registers
    logic [MAG_W-1:0]  mag_sh;
    logic [GRID_W-1:0] grid_min_sh;
    logic              grid_shown_sh;

    mag_row_t rows_due[$];
    mag_row_t got_row;
    mag_row_t want_row;

    function automatic int unsigned clamp_mag(input logic [MAG_W-1:0] m);
        int unsigned v;
        v = 32'(m);
        if (v < 1)
            v = 1;
        if (v > MAX_MAG_LOG2_DEF)
            v = MAX_MAG_LOG2_DEF;
        return v;
    endfunction

    // expand one source byte into its magnified rows and queue them
    function automatic void queue_magnified_rows(input logic [SRC_W-1:0] src,
                                                 input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
        int unsigned       m;
        int unsigned       f;
        int unsigned       col_w;
        int unsigned       row_w;
        logic [ROW_PIX_W-1:0] line;
        logic [CELL_W-1:0] cell_mask;
        bit                gaps;
        mag_row_t          r;
        m     = clamp_mag(mag_sh);
        f     = 1 << m;
        col_w = col % (BITMAP_SIZE_DEF / 8);
        row_w = row % BITMAP_SIZE_DEF;
        line  = '0;
        for (int i = 0; i < 8; i++)
            if (src[i])
                for (int b = 0; b < f; b++)
                    line[i * f + b] = 1'b1;
        gaps = (f > 2) && ((m < grid_min_sh) || !grid_shown_sh);
        if (gaps)
        begin
            case (m)
                2:       cell_mask = 16'h7777;
                3:       cell_mask = 16'h7F7F;
                default: cell_mask = 16'h7FFF;
            endcase
            line = line & {8{cell_mask}};
        end
        for (int k = 0; k < f; k++)
        begin
            r.dest_row = COORD_W'(row_w * f + k);
            r.dest_x   = COORD_W'(col_w * 8 * f);
            // with gaps the bottom row of every cell stays dark
            if (gaps && k == f - 1)
            begin
                r.pixels_lo = '0;
                r.pixels_hi = '0;
            end
            else
            begin
                r.pixels_lo = line[PIX_W-1:0];
                r.pixels_hi = line[ROW_PIX_W-1:PIX_W];
            end
            r.last = (k == f - 1);
            rows_due.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_sh        = MAG_RESET;
            grid_min_sh   = GRID_MIN_RESET;
            grid_shown_sh = 1'b0;
            rows_due.delete();
            fails         = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAG_LOG2:   mag_sh        = cfg_data[MAG_W-1:0];
                    CFG_GRID_MIN:   grid_min_sh   = cfg_data[GRID_W-1:0];
                    CFG_GRID_SHOWN: grid_shown_sh = cfg_data[0];
                    default:        ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got_row = '{out_mon.dest_row, out_mon.dest_x, out_mon.pixels_lo,
                            out_mon.pixels_hi, out_mon.last};
                if (rows_due.size() == 0)
                    report_mismatch("row with nothing due (dest_row)", '0,
                                    64'(got_row.dest_row));
                else
                begin
                    want_row = rows_due.pop_front();
                    if (got_row.dest_row !== want_row.dest_row)
                        report_mismatch("dest_row", 64'(want_row.dest_row),
                                        64'(got_row.dest_row));
                    if (got_row.dest_x !== want_row.dest_x)
                        report_mismatch("dest_x", 64'(want_row.dest_x), 64'(got_row.dest_x));
                    if (got_row.pixels_lo !== want_row.pixels_lo)
                        report_mismatch("pixels_lo", want_row.pixels_lo, got_row.pixels_lo);
                    if (got_row.pixels_hi !== want_row.pixels_hi)
                        report_mismatch("pixels_hi", want_row.pixels_hi, got_row.pixels_hi);
                    if (got_row.last !== want_row.last)
                        report_mismatch("last", 64'(want_row.last), 64'(got_row.last));
                end
            end
            if (in_mon.valid && in_mon.ready)
                queue_magnified_rows(in_mon.src_byte, in_mon.byte_col, in_mon.src_row);
            pending <= rows_due.size();
        end
    end

endmodule

@@ verif/mono_bitmap_magnifier_tb.sv @@
// testbench top for the mono bitmap magnifier: clock, reset, stimulus and verdict
module mono_bitmap_magnifier_tb;
    import mbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 10;
    localparam int HOLD_PHASE    = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fails;
    int                    pending;
    bit                    hold_req;
    bit                    tx_steady;

    mbm_in_if  in_ch ();
    mbm_out_if out_ch ();

    mono_bitmap_magnifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    mbm_row_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offer one byte after a random gap and wait until it is taken
    task automatic send_byte(input logic [SRC_W-1:0] src, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.src_byte <= src;
        in_ch.byte_col <= col;
        in_ch.src_row  <= row;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves the write enable high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [CFG_DATA_W-1:0] mag, input logic [CFG_DATA_W-1:0] gmin,
                            input logic [CFG_DATA_W-1:0] shown, input bit poke_unused);
        wait_idle();
        if (poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_MAG_LOG2, mag);
        write_reg(CFG_GRID_MIN, gmin);
        write_reg(CFG_GRID_SHOWN, shown);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : row_sink
        int gap;
        int steady_left;
        steady_left = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // long hold-off so the block backs up into its input
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (steady_left > 0)
            begin
                gap = 0;
                steady_left--;
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0)
                    steady_left = 40;
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_MAG_LOG2;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.src_byte = '0;
        in_ch.byte_col = '0;
        in_ch.src_row  = '0;
        out_ch.ready   = 1'b0;
        hold_req       = 1'b0;
        tx_steady      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings after reset: 2x, no gaps
        send_byte(8'h00, 5'd0, 8'd0);
        send_byte(8'hFF, 5'd31, 8'd255);
        send_byte(8'h01, 5'd1, 8'd1);
        // zero factor acts as 2x, and a write to the unused index changes nothing
        set_mode(4'd0, 4'd2, 4'd0, 1'b1);
        send_byte(8'h80, 5'd16, 8'd128);
        // 4x at the grid threshold with grid hidden: gaps
        set_mode(4'd2, 4'd2, 4'd0, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        send_byte(8'h55, 5'd10, 8'd7);
        // 4x with grid shown: no gaps
        set_mode(4'd2, 4'd2, 4'd1, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        // 8x below the threshold: gaps even with grid shown
        set_mode(4'd3, 4'd15, 4'd1, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        send_byte(8'hAA, 5'd5, 8'd200);
        // 16x with grid shown: no gaps, full 128 pixels
        set_mode(4'd4, 4'd0, 4'd1, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        // factors above the maximum saturate to 16x
        set_mode(4'd7, 4'd4, 4'd0, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        send_byte(8'h0F, 5'd0, 8'd0);
        set_mode(4'd5, 4'd15, 4'd0, 1'b1);
        send_byte(8'hF0, 5'd20, 8'd64);
        // 2x never has gaps, even below the threshold
        set_mode(4'd1, 4'd15, 4'd1, 1'b0);
        send_byte(8'hFF, 5'd31, 8'd255);
        set_mode(4'd6, 4'd8, 4'd1, 1'b0);
        send_byte(8'h3C, 5'd9, 8'd99);
        // upper data bits beyond each register are dropped
        set_mode(4'hC, 4'd3, 4'hE, 1'b1);
        send_byte(8'hC3, 5'd17, 8'd170);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_mode(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)),
                     CFG_DATA_W'($urandom_range(0, 15)), ($urandom_range(0, 3) == 0));
            tx_steady = ($urandom_range(0, 3) == 0);
            if (p == HOLD_PHASE)
            begin
                tx_steady = 1'b1;
                hold_req  = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_byte(SRC_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 31)),
                          ROW_W'($urandom_range(0, 255)));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mbm_pkg.sv
sv/mbm_if.sv
sv/mbm_lane.sv
sv/mbm_merge.sv
sv/mono_bitmap_magnifier.sv
verif/mbm_row_checker.sv
verif/mono_bitmap_magnifier_tb.sv
